>>> hw/rtl/clnw_pkg.sv
package clnw_pkg;

  // Field widths fixed by the pin interface
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned COLUMN_W  = 6;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned HOLD_W    = 17;
  localparam int unsigned EHOLD_W   = 10;
  localparam int unsigned SETTLE_W  = 14;
  localparam int unsigned SLOW_W    = 16;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned PHASE_W   = 5;

  localparam int unsigned MAX_COLUMN_DEF = 39;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_INIT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CMD    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DATA   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CURSOR = 2'd3;

  // Register indexes (word address)
  localparam logic [1:0] REG_ENABLE_HOLD = 2'd0;
  localparam logic [1:0] REG_SETTLE      = 2'd1;
  localparam logic [1:0] REG_SLOW_CMD    = 2'd2;
  localparam logic [1:0] REG_POWERUP     = 2'd3;

  // Register reset values
  localparam logic [EHOLD_W-1:0]  ENABLE_HOLD_RST = 10'd1;
  localparam logic [SETTLE_W-1:0] SETTLE_RST      = 14'd250;
  localparam logic [SLOW_W-1:0]   SLOW_CMD_RST    = 16'd5000;
  localparam logic [HOLD_W-1:0]   POWERUP_RST     = 17'd50000;

  // LCD command constants
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] DDRAM_ROW0    = 8'h80;
  localparam logic [7:0] DDRAM_ROW1    = 8'hC0;
  localparam logic [NIBBLE_W-1:0] NIB_WAKE     = 4'h3;
  localparam logic [NIBBLE_W-1:0] NIB_FOUR_BIT = 4'h2;
  localparam logic [SLOW_W-1:0]   FIRST_GAP_US = 16'd5000;
  localparam logic [SLOW_W-1:0]   SHORT_GAP_US = 16'd150;

  // Init phase layout: wait, 8 wake-up phases, then 5 bytes of 4 phases
  localparam logic [PHASE_W-1:0] INIT_BYTE_START = 5'd9;
  localparam logic [PHASE_W-1:0] INIT_LAST_PHASE = 5'd28;
  localparam logic [PHASE_W-1:0] BYTE_LAST_PHASE = 5'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [7:0]          byte_value;
    logic                cursor_row;
    logic [COLUMN_W-1:0] cursor_column;
  } in_item_t;

  typedef struct packed {
    logic                register_select;
    logic                enable_level;
    logic [NIBBLE_W-1:0] data_nibble;
    logic [HOLD_W-1:0]   hold_time_us;
    logic                final_phase;
  } out_item_t;

  typedef struct packed {
    logic [EHOLD_W-1:0]  enable_hold_us;
    logic [SETTLE_W-1:0] settle_us;
    logic [SLOW_W-1:0]   slow_command_us;
    logic [HOLD_W-1:0]   powerup_us;
  } cfg_t;

  typedef struct packed {
    logic load;   // capture a new request, restart phase count
    logic emit;   // load the current phase into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic last;      // current phase is the final one of the request
    logic out_free;  // output register can take a phase this cycle
  } ctl_sts_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctl_state_t;

endpackage

>>> hw/rtl/char_lcd_nibble_writer_core.sv
// 4-bit character LCD pin sequencer.
// Input channel (in_valid / in_stall / in_item): one request per item, one of
//   init sequence, command byte, data byte or set cursor.
// Output channel (out_valid / out_stall / out_item): one pin phase per item:
//   register select, enable level, D4..D7 nibble, hold time in us, and a
//   final_phase flag on the last phase of each request.
// Config port (APB-style, pready tied high): four timing registers at byte
//   addresses 0x0, 0x4, 0x8, 0xC; write only while the block is idle.
// First phase: once a request is taken, its first phase is loaded into the
//   output register when that register is free, and out_valid rises with it.
// Throughput: one phase per cycle while out_stall is low, paced by the phase
//   counter in the datapath. A byte or cursor request has four phases and init
//   has 29 (a wait, eight wake-up phases, five bytes of four phases). The
//   next request is taken in the cycle after the final phase has been loaded,
//   while that phase may still sit in the output register.
// Stall: out_stall freezes the output register and the phase counter; the
//   request channel stays stalled until the sequence is finished.
// Reset: sequencer goes idle, output register empties, timing registers go
//   back to 1 / 250 / 5000 / 50000 us.
module char_lcd_nibble_writer_core
  import clnw_pkg::*;
#(
  parameter int unsigned MAX_COLUMN = MAX_COLUMN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  // phase channel
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t     cfg;
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // timing registers
  clnw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // idle/run sequencer: takes a request, then steps phases as output frees
  clnw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // request register, phase counter, phase decode and output register
  clnw_datapath #(
    .MAX_COLUMN (MAX_COLUMN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> hw/rtl/clnw_cfg_regs.sv
module clnw_cfg_regs
  import clnw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_ENABLE_HOLD: cfg_nxt.enable_hold_us  = pwdata[EHOLD_W-1:0];
        REG_SETTLE:      cfg_nxt.settle_us       = pwdata[SETTLE_W-1:0];
        REG_SLOW_CMD:    cfg_nxt.slow_command_us = pwdata[SLOW_W-1:0];
        REG_POWERUP:     cfg_nxt.powerup_us      = pwdata[HOLD_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_hold_us  <= ENABLE_HOLD_RST;
      cfg_r.settle_us       <= SETTLE_RST;
      cfg_r.slow_command_us <= SLOW_CMD_RST;
      cfg_r.powerup_us      <= POWERUP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ENABLE_HOLD: prdata = PDATA_W'(cfg_r.enable_hold_us);
      REG_SETTLE:      prdata = PDATA_W'(cfg_r.settle_us);
      REG_SLOW_CMD:    prdata = PDATA_W'(cfg_r.slow_command_us);
      REG_POWERUP:     prdata = PDATA_W'(cfg_r.powerup_us);
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/clnw_ctrl.sv
module clnw_ctrl
  import clnw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.emit = sts.out_free;
        if (sts.out_free && sts.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/clnw_datapath.sv
module clnw_datapath
  import clnw_pkg::*;
#(
  parameter int unsigned MAX_COLUMN = MAX_COLUMN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  input  ctl_cmd_t  cmd,
  output ctl_sts_t  sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  in_item_t           req_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [PHASE_W-1:0] q;
  logic [1:0]         sub;
  logic [1:0]         wake_idx;
  logic [7:0]         cur_byte;
  logic [COLUMN_W-1:0] col;
  logic               is_wait, is_wake, rs, slow;
  logic [SLOW_W-1:0]  extra;

  function automatic logic [7:0] init_cmd(input logic [2:0] j);
    case (j)
      3'd0:    init_cmd = CMD_FUNC_SET;
      3'd1:    init_cmd = CMD_DISP_OFF;
      3'd2:    init_cmd = CMD_CLEAR;
      3'd3:    init_cmd = CMD_ENTRY;
      default: init_cmd = CMD_DISP_ON;
    endcase
  endfunction

  assign q        = phase_r - INIT_BYTE_START;
  assign wake_idx = 2'((phase_r - 5'd1) >> 1);
  assign col      = (req_r.cursor_column > COLUMN_W'(MAX_COLUMN))
                    ? COLUMN_W'(MAX_COLUMN) : req_r.cursor_column;

  // Phase decode: pick the byte and nibble slot, then form the pins
  always_comb begin
    is_wait  = 1'b0;
    is_wake  = 1'b0;
    sub      = phase_r[1:0];
    rs       = 1'b0;
    cur_byte = req_r.byte_value;
    case (req_r.opcode)
      OP_INIT: begin
        if (phase_r == '0) begin
          is_wait = 1'b1;
        end else if (phase_r < INIT_BYTE_START) begin
          is_wake = 1'b1;
        end else begin
          sub      = q[1:0];
          cur_byte = init_cmd(q[4:2]);
        end
      end
      OP_DATA:   rs = 1'b1;
      OP_CURSOR: cur_byte = (req_r.cursor_row ? DDRAM_ROW1 : DDRAM_ROW0) + 8'(col);
      default:   cur_byte = req_r.byte_value;
    endcase

    slow  = !rs && (cur_byte == CMD_CLEAR || cur_byte == CMD_HOME) && (sub == 2'd3);
    extra = slow ? cfg.slow_command_us : '0;

    out_nxt.register_select = rs;
    out_nxt.final_phase     = sts.last;
    if (is_wait) begin
      out_nxt.enable_level = 1'b0;
      out_nxt.data_nibble  = '0;
      out_nxt.hold_time_us = cfg.powerup_us;
    end else if (is_wake) begin
      out_nxt.enable_level = phase_r[0];
      out_nxt.data_nibble  = (wake_idx == 2'd3) ? NIB_FOUR_BIT : NIB_WAKE;
      out_nxt.hold_time_us = phase_r[0] ? HOLD_W'(cfg.enable_hold_us)
                           : HOLD_W'(cfg.settle_us)
                             + HOLD_W'((wake_idx == 2'd0) ? FIRST_GAP_US : SHORT_GAP_US);
    end else begin
      out_nxt.enable_level = ~sub[0];
      out_nxt.data_nibble  = sub[1] ? cur_byte[3:0] : cur_byte[7:4];
      out_nxt.hold_time_us = sub[0] ? HOLD_W'(cfg.settle_us) + HOLD_W'(extra)
                           : HOLD_W'(cfg.enable_hold_us);
    end
  end

  assign sts.last     = (req_r.opcode == OP_INIT) ? (phase_r == INIT_LAST_PHASE)
                                                  : (phase_r == BYTE_LAST_PHASE);
  assign sts.out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (cmd.load) begin
      phase_nxt = '0;
    end else if (cmd.emit) begin
      phase_nxt     = phase_r + 5'd1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
